// File: hw/rtl/sas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared widths, codes, types and the divider digit function of the sprite
// animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int MAX_STEPS          = 16;
    localparam int PROGRESS_FRAC_BITS = 16;

    localparam int STEP_W     = $clog2(MAX_STEPS);
    localparam int CNT_W      = $clog2(MAX_STEPS + 1);
    localparam int PROG_W     = 24;
    localparam int DELTA_W    = 16;
    localparam int DUR_W      = 16;
    localparam int CELL_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int IMG_W      = 13;
    localparam int CNT_CFG_W  = 5;
    localparam int SIZE_W     = 16;
    localparam int OUT_W      = 20;
    localparam int CSTEP_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIDE_W     = 32;

    // progress divider: quotient digits of DIG bits, one digit per stage
    localparam int QUO_W   = DELTA_W + PROGRESS_FRAC_BITS;
    localparam int DIG     = 4;
    localparam int DIV_STG = (QUO_W + DIG - 1) / DIG;
    localparam int DVD_W   = DIV_STG * DIG;
    localparam int SUM_W   = DVD_W + 1;

    localparam logic [PROG_W-1:0] PROG_MAX = '1;
    localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

    // register reset values
    localparam logic [CNT_CFG_W-1:0] RST_STEP_COUNT = CNT_CFG_W'(1);
    localparam logic [IMG_W-1:0]     RST_IMG_SIZE   = IMG_W'(256);
    localparam logic [CELL_W-1:0]    RST_CELLS      = CELL_W'(1);

    typedef enum logic {
        REQ_WRITE   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT   = 3'd0,
        CFG_REPEAT_MODE  = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_CELLS_ACROSS = 3'd4,
        CFG_CELLS_DOWN   = 3'd5,
        CFG_SIZE_FACTOR  = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        GEOM_LOAD,
        GEOM_DIV,
        GEOM_SCALE,
        GEOM_DONE
    } t_geom_state;

    // configuration and derived geometry seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             repeat_en;
        logic [IMG_W-1:0] cell_w;
        logic [IMG_W-1:0] cell_h;
        logic [OUT_W-1:0] scaled_w;
        logic [OUT_W-1:0] scaled_h;
        logic             size_valid;
        logic             busy;
    } t_cfg;

    // item sideband carried down the pipeline
    typedef struct packed {
        logic              adv;
        logic              past;
        logic [PROG_W-1:0] prog;
        logic              wr_en;
        logic [STEP_W-1:0] wr_addr;
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
    } t_side;

    typedef struct packed {
        logic [DUR_W-1:0] rem;
        logic [DIG-1:0]   q;
    } t_div_res;

    // DIG steps of restoring division, dividend bits MSB first
    function automatic t_div_res div_digit(input logic [DUR_W-1:0] rem,
                                           input logic [DIG-1:0]   bits,
                                           input logic [DUR_W-1:0] dvs);
        logic [DUR_W:0]   t;
        logic [DUR_W-1:0] r;
        logic [DIG-1:0]   q;
        t_div_res         res;
        r = rem;
        q = '0;
        for (int k = DIG - 1; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, dvs}) begin
                t    = t - {1'b0, dvs};
                q[k] = 1'b1;
            end
            r = t[DUR_W-1:0];
        end
        res.rem = r;
        res.q   = q;
        return res;
    endfunction

endpackage

// File: hw/rtl/sas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sas_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_geom
// Configuration registers and the sequencer that derives cell size and
// scaled size from them after reset and after every register write.
// ----------------------------------------------------------------------------
module sas_geom (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sas_pkg::t_cfg                    o_cfg
);

    localparam int BIT_W  = $clog2(sas_pkg::IMG_W);
    localparam int PROD_W = sas_pkg::IMG_W + sas_pkg::SIZE_W;
    localparam int SHR_W  = PROD_W - 8;

    sas_pkg::t_geom_state r_state, n_state;

    logic [sas_pkg::CNT_CFG_W-1:0] r_step_count;
    logic                          r_repeat;
    logic [sas_pkg::IMG_W-1:0]     r_img_w, r_img_h;
    logic [sas_pkg::CELL_W-1:0]    r_across, r_down;
    logic [sas_pkg::SIZE_W-1:0]    r_size;

    logic [sas_pkg::CELL_W-1:0]    r_rem_w, r_rem_h;
    logic [sas_pkg::IMG_W-1:0]     r_quo_w, r_quo_h;
    logic [BIT_W-1:0]              r_bit;
    logic [sas_pkg::OUT_W-1:0]     r_scaled_w, r_scaled_h;

    logic [sas_pkg::CELL_W-1:0]    w_dvs_w, w_dvs_h;
    logic [sas_pkg::CELL_W:0]      w_t_w, w_t_h, w_td_w, w_td_h;
    logic                          w_ge_w, w_ge_h;
    logic [PROD_W-1:0]             w_prod_w, w_prod_h;
    logic [SHR_W-1:0]              w_shr_w, w_shr_h;
    logic [sas_pkg::WIDE_W-1:0]    w_sc32, w_cnt32;
    logic                          w_busy;

    // zero cell counts act as one
    assign w_dvs_w = (r_across == '0) ? sas_pkg::CELL_W'(1) : r_across;
    assign w_dvs_h = (r_down == '0)   ? sas_pkg::CELL_W'(1) : r_down;

    assign w_t_w  = {r_rem_w, r_quo_w[sas_pkg::IMG_W-1]};
    assign w_t_h  = {r_rem_h, r_quo_h[sas_pkg::IMG_W-1]};
    assign w_td_w = w_t_w - {1'b0, w_dvs_w};
    assign w_td_h = w_t_h - {1'b0, w_dvs_h};
    assign w_ge_w = (w_t_w >= {1'b0, w_dvs_w});
    assign w_ge_h = (w_t_h >= {1'b0, w_dvs_h});

    assign w_prod_w = PROD_W'(r_quo_w) * PROD_W'(r_size);
    assign w_prod_h = PROD_W'(r_quo_h) * PROD_W'(r_size);
    assign w_shr_w  = w_prod_w[PROD_W-1:8];
    assign w_shr_h  = w_prod_h[PROD_W-1:8];

    // steps in use: 0 acts as 1, capped at the table depth
    assign w_sc32 = sas_pkg::WIDE_W'(r_step_count);
    always_comb begin
        if (w_sc32 == '0) begin
            w_cnt32 = sas_pkg::WIDE_W'(1);
        end else if (w_sc32 > sas_pkg::WIDE_W'(sas_pkg::MAX_STEPS)) begin
            w_cnt32 = sas_pkg::WIDE_W'(sas_pkg::MAX_STEPS);
        end else begin
            w_cnt32 = w_sc32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sas_pkg::GEOM_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_busy  = (r_state != sas_pkg::GEOM_DONE);
        priority if (i_cfg_we) begin
            n_state = sas_pkg::GEOM_LOAD;
        end else begin
            unique case (r_state)
                sas_pkg::GEOM_LOAD: n_state = sas_pkg::GEOM_DIV;
                sas_pkg::GEOM_DIV: begin
                    if (r_bit == BIT_W'(sas_pkg::IMG_W - 1)) begin
                        n_state = sas_pkg::GEOM_SCALE;
                    end
                end
                sas_pkg::GEOM_SCALE: n_state = sas_pkg::GEOM_DONE;
                sas_pkg::GEOM_DONE:  n_state = sas_pkg::GEOM_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= sas_pkg::RST_STEP_COUNT;
            r_repeat     <= 1'b0;
            r_img_w      <= sas_pkg::RST_IMG_SIZE;
            r_img_h      <= sas_pkg::RST_IMG_SIZE;
            r_across     <= sas_pkg::RST_CELLS;
            r_down       <= sas_pkg::RST_CELLS;
            r_size       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sas_pkg::CFG_STEP_COUNT:
                    r_step_count <= i_cfg_data[sas_pkg::CNT_CFG_W-1:0];
                sas_pkg::CFG_REPEAT_MODE:  r_repeat <= i_cfg_data[0];
                sas_pkg::CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[sas_pkg::IMG_W-1:0];
                sas_pkg::CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[sas_pkg::IMG_W-1:0];
                sas_pkg::CFG_CELLS_ACROSS: r_across <= i_cfg_data[sas_pkg::CELL_W-1:0];
                sas_pkg::CFG_CELLS_DOWN:   r_down   <= i_cfg_data[sas_pkg::CELL_W-1:0];
                sas_pkg::CFG_SIZE_FACTOR:  r_size   <= i_cfg_data[sas_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // bit-serial restoring division of both image sizes, then the scale product
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sas_pkg::GEOM_LOAD: begin
                r_rem_w <= '0;
                r_rem_h <= '0;
                r_quo_w <= r_img_w;
                r_quo_h <= r_img_h;
                r_bit   <= '0;
            end
            sas_pkg::GEOM_DIV: begin
                r_rem_w <= w_ge_w ? w_td_w[sas_pkg::CELL_W-1:0] : w_t_w[sas_pkg::CELL_W-1:0];
                r_rem_h <= w_ge_h ? w_td_h[sas_pkg::CELL_W-1:0] : w_t_h[sas_pkg::CELL_W-1:0];
                r_quo_w <= {r_quo_w[sas_pkg::IMG_W-2:0], w_ge_w};
                r_quo_h <= {r_quo_h[sas_pkg::IMG_W-2:0], w_ge_h};
                r_bit   <= r_bit + BIT_W'(1);
            end
            sas_pkg::GEOM_SCALE: begin
                r_scaled_w <= (w_shr_w > SHR_W'(sas_pkg::OUT_MAX)) ? sas_pkg::OUT_MAX
                            : w_shr_w[sas_pkg::OUT_W-1:0];
                r_scaled_h <= (w_shr_h > SHR_W'(sas_pkg::OUT_MAX)) ? sas_pkg::OUT_MAX
                            : w_shr_h[sas_pkg::OUT_W-1:0];
            end
            sas_pkg::GEOM_DONE: ;
        endcase
    end

    assign o_cfg.count      = w_cnt32[sas_pkg::CNT_W-1:0];
    assign o_cfg.repeat_en  = r_repeat;
    assign o_cfg.cell_w     = r_quo_w;
    assign o_cfg.cell_h     = r_quo_h;
    assign o_cfg.scaled_w   = r_scaled_w;
    assign o_cfg.scaled_h   = r_scaled_h;
    assign o_cfg.size_valid = (r_size != '0);
    assign o_cfg.busy       = w_busy;

endmodule

// File: hw/rtl/sprite_animation_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// Sprite-sheet frame animator: step table writes and progress advances.
// ----------------------------------------------------------------------------
// Takes one item per cycle, write or advance, whenever o_stall is low; the
// pipeline holds under output back-pressure. The progress divider is a
// pipeline of DIV_STG stages that each resolve 4 quotient bits of delta /
// duration. The step table lives in two RAMs: durations are read as an item
// is taken and written there by write items; column and row are read and
// written at the stage after the divider, so every access meets them in item
// order. After reset and after each register write the input stalls while the
// cell and scaled sizes are derived bit-serially. Write items give no result.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_req_type,
    input  logic [sas_pkg::SLOT_W-1:0]         i_step_slot,
    input  logic [sas_pkg::DUR_W-1:0]          i_step_duration,
    input  logic [sas_pkg::CELL_W-1:0]         i_source_col,
    input  logic [sas_pkg::CELL_W-1:0]         i_source_row,
    input  logic [sas_pkg::PROG_W-1:0]         i_progress_in,
    input  logic [sas_pkg::DELTA_W-1:0]        i_delta_time,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sas_pkg::PROG_W-1:0]         o_progress_out,
    output logic [sas_pkg::CSTEP_W-1:0]        o_current_step,
    output logic                               o_finished,
    output logic [sas_pkg::OUT_W-1:0]          o_src_x,
    output logic [sas_pkg::OUT_W-1:0]          o_src_y,
    output logic [sas_pkg::IMG_W-1:0]          o_cell_width,
    output logic [sas_pkg::IMG_W-1:0]          o_cell_height,
    output logic [sas_pkg::OUT_W-1:0]          o_scaled_width,
    output logic [sas_pkg::OUT_W-1:0]          o_scaled_height,
    output logic                               o_size_valid
);

    localparam int L     = sas_pkg::DIV_STG;
    localparam int MUL_W = sas_pkg::CELL_W + sas_pkg::IMG_W;
    localparam int CR_W  = 2 * sas_pkg::CELL_W;

    sas_pkg::t_cfg w_cfg;

    sas_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // pipeline registers: stage 0 holds the taken item, 1..L the divider
    logic                        r_vld  [0:L];
    sas_pkg::t_side              r_side [0:L];
    logic [sas_pkg::DVD_W-1:0]   r_dvd  [0:L-1];
    logic [sas_pkg::DUR_W-1:0]   r_rem  [1:L-1];
    logic [sas_pkg::DUR_W-1:0]   r_dvs  [1:L-1];
    logic [sas_pkg::DVD_W-1:0]   r_quo  [1:L];
    logic                        w_rdy  [0:L];

    logic                        r_e_vld;
    logic [sas_pkg::PROG_W-1:0]  r_e_prog;
    logic [sas_pkg::STEP_W-1:0]  r_e_shown;
    logic                        r_e_fin;

    logic                        r_o_valid;
    logic [sas_pkg::PROG_W-1:0]  r_o_prog;
    logic [sas_pkg::CSTEP_W-1:0] r_o_step;
    logic                        r_o_fin;
    logic [sas_pkg::OUT_W-1:0]   r_o_src_x, r_o_src_y;

    logic                        w_rdy_out, w_rdy_e, w_accept;

    // ---------------------------------------------------------------- intake
    logic [sas_pkg::WIDE_W-1:0]  w_prog32, w_prev32, w_cnt32, w_slot32;
    logic                        w_is_adv, w_slot_ok;
    logic [sas_pkg::DUR_W-1:0]   w_dur_wdata, w_dur_rdata;
    sas_pkg::t_side              w_side0;

    assign w_rdy_out = !r_o_valid || !i_stall;
    assign w_rdy_e   = !r_e_vld || w_rdy_out;
    assign o_stall   = !w_rdy[0] || w_cfg.busy;
    assign w_accept  = i_valid && !o_stall;

    assign w_prog32  = sas_pkg::WIDE_W'(i_progress_in);
    assign w_prev32  = w_prog32 >> sas_pkg::PROGRESS_FRAC_BITS;
    assign w_cnt32   = sas_pkg::WIDE_W'(w_cfg.count);
    assign w_slot32  = sas_pkg::WIDE_W'(i_step_slot);
    assign w_is_adv  = (i_req_type == sas_pkg::REQ_ADVANCE);
    assign w_slot_ok = (w_slot32 < sas_pkg::WIDE_W'(sas_pkg::MAX_STEPS));

    assign w_dur_wdata = (i_step_duration == '0) ? sas_pkg::DUR_W'(1) : i_step_duration;

    assign w_side0.adv     = w_is_adv;
    assign w_side0.past    = (w_prev32 >= w_cnt32);
    assign w_side0.prog    = i_progress_in;
    assign w_side0.wr_en   = w_slot_ok;
    assign w_side0.wr_addr = w_slot32[sas_pkg::STEP_W-1:0];
    assign w_side0.col     = i_source_col;
    assign w_side0.row     = i_source_row;

    sas_ram #(
        .WIDTH (sas_pkg::DUR_W),
        .DEPTH (sas_pkg::MAX_STEPS)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_is_adv && w_slot_ok),
        .i_waddr (w_slot32[sas_pkg::STEP_W-1:0]),
        .i_wdata (w_dur_wdata),
        .i_re    (w_accept && w_is_adv),
        .i_raddr (w_prev32[sas_pkg::STEP_W-1:0]),
        .o_rdata (w_dur_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_vld[0] <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_side[0] <= w_side0;
            r_dvd[0]  <= sas_pkg::DVD_W'({i_delta_time, {sas_pkg::PROGRESS_FRAC_BITS{1'b0}}});
        end
    end

    // --------------------------------------------------------------- divider
    genvar k;
    generate
        for (k = 1; k <= L; k++) begin : g_div
            logic [sas_pkg::DUR_W-1:0] w_rem_in, w_dvs_in;
            logic [sas_pkg::DVD_W-1:0] w_quo_in;
            sas_pkg::t_div_res         w_res;

            if (k == 1) begin : g_first
                assign w_rem_in = '0;
                assign w_quo_in = '0;
                assign w_dvs_in = w_dur_rdata;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_quo_in = r_quo[k-1];
                assign w_dvs_in = r_dvs[k-1];
            end

            assign w_res = sas_pkg::div_digit(w_rem_in,
                                              r_dvd[k-1][sas_pkg::DVD_W-1 -: sas_pkg::DIG],
                                              w_dvs_in);

            if (k < L) begin : g_ready_mid
                assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
            end else begin : g_ready_last
                assign w_rdy[k] = !r_vld[k] || w_rdy_e;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_side[k] <= r_side[k-1];
                    r_quo[k]  <= {w_quo_in[sas_pkg::DVD_W-sas_pkg::DIG-1:0], w_res.q};
                end
            end

            if (k < L) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_dvd[k] <= r_dvd[k-1] << sas_pkg::DIG;
                        r_rem[k] <= w_res.rem;
                        r_dvs[k] <= w_dvs_in;
                    end
                end
            end
        end
    endgenerate

    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    // ------------------------------------------------------ step resolution
    sas_pkg::t_side              w_sl;
    logic [sas_pkg::SUM_W-1:0]   w_sum;
    logic [sas_pkg::PROG_W-1:0]  w_adv_prog, w_nprog;
    logic [sas_pkg::WIDE_W-1:0]  w_lprev32, w_nstep32, w_last32, w_shown32;
    logic                        w_fin;
    logic [CR_W-1:0]             w_cr_rdata;

    assign w_sl       = r_side[L];
    assign w_sum      = sas_pkg::SUM_W'(w_sl.prog) + sas_pkg::SUM_W'(r_quo[L]);
    assign w_adv_prog = (w_sum > sas_pkg::SUM_W'(sas_pkg::PROG_MAX)) ? sas_pkg::PROG_MAX
                      : w_sum[sas_pkg::PROG_W-1:0];
    assign w_lprev32  = sas_pkg::WIDE_W'(w_sl.prog) >> sas_pkg::PROGRESS_FRAC_BITS;
    assign w_nstep32  = sas_pkg::WIDE_W'(w_adv_prog) >> sas_pkg::PROGRESS_FRAC_BITS;
    assign w_last32   = w_cnt32 - sas_pkg::WIDE_W'(1);

    always_comb begin
        if (w_sl.past) begin
            w_nprog   = w_sl.prog;
            w_shown32 = w_last32;
            w_fin     = 1'b1;
        end else begin
            w_nprog   = w_adv_prog;
            w_shown32 = w_nstep32;
            w_fin     = 1'b0;
            // ran past the last step
            if (w_nstep32 != w_lprev32 && w_nstep32 >= w_cnt32) begin
                w_fin = 1'b1;
                if (w_cfg.repeat_en) begin
                    w_shown32 = '0;
                    w_nprog   = '0;
                end else begin
                    w_shown32 = w_last32;
                end
            end
        end
    end

    sas_ram #(
        .WIDTH (CR_W),
        .DEPTH (sas_pkg::MAX_STEPS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_rdy_e && r_vld[L] && !w_sl.adv && w_sl.wr_en),
        .i_waddr (w_sl.wr_addr),
        .i_wdata ({w_sl.col, w_sl.row}),
        .i_re    (w_rdy_e && r_vld[L] && w_sl.adv),
        .i_raddr (w_shown32[sas_pkg::STEP_W-1:0]),
        .o_rdata (w_cr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_rdy_e) begin
            r_e_vld <= r_vld[L] && w_sl.adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_e) begin
            r_e_prog  <= w_nprog;
            r_e_shown <= w_shown32[sas_pkg::STEP_W-1:0];
            r_e_fin   <= w_fin;
        end
    end

    // ---------------------------------------------------------- output stage
    logic [MUL_W-1:0]            w_px, w_py;
    logic [sas_pkg::WIDE_W-1:0]  w_shown_ext;

    assign w_px        = MUL_W'(w_cr_rdata[CR_W-1:sas_pkg::CELL_W]) * MUL_W'(w_cfg.cell_w);
    assign w_py        = MUL_W'(w_cr_rdata[sas_pkg::CELL_W-1:0]) * MUL_W'(w_cfg.cell_h);
    assign w_shown_ext = sas_pkg::WIDE_W'(r_e_shown);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_o_valid <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_o_prog  <= r_e_prog;
            r_o_step  <= w_shown_ext[sas_pkg::CSTEP_W-1:0];
            r_o_fin   <= r_e_fin;
            r_o_src_x <= (w_px > MUL_W'(sas_pkg::OUT_MAX)) ? sas_pkg::OUT_MAX
                       : w_px[sas_pkg::OUT_W-1:0];
            r_o_src_y <= (w_py > MUL_W'(sas_pkg::OUT_MAX)) ? sas_pkg::OUT_MAX
                       : w_py[sas_pkg::OUT_W-1:0];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_progress_out  = r_o_prog;
    assign o_current_step  = r_o_step;
    assign o_finished      = r_o_fin;
    assign o_src_x         = r_o_src_x;
    assign o_src_y         = r_o_src_y;
    // user holds geometry still while items are in flight; not enforced
    assign o_cell_width    = w_cfg.cell_w;
    assign o_cell_height   = w_cfg.cell_h;
    assign o_scaled_width  = w_cfg.scaled_w;
    assign o_scaled_height = w_cfg.scaled_h;
    assign o_size_valid    = w_cfg.size_valid;

endmodule
